// ===== src/sfips_pkg.sv =====
package sfips_pkg;

  localparam int unsigned MAX_BASIS_DEF = 16;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned BASIS_W       = 5;
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned FIFO_DEPTH    = 2;

  localparam logic [BASIS_W-1:0] BASIS_RESET = 5'd16;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic wr;
    logic err;
  } op_t;

  localparam int unsigned OP_W = $bits(op_t);

endpackage

// ===== src/symmetric_four_index_packed_store_core.sv =====
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: a,b,c,d,write_value; tuser: func
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: read_value; tuser: range_error
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_data_i: basis_count
//
// Throughput is set by the back end: a popped beat holds the RAM read slot
// until its data lands in the output register, and no new beat is popped meanwhile.
// A result passes the two front stages, the queue, the RAM read and the output register.
// After reset a clearing pass zeroes the store, one word per cycle:
// P*(P+1)/2 words, P = MaxBasis*(MaxBasis+1)/2 (9316 at MaxBasis 16);
// s_axis_tready stays low meanwhile, cfg writes are taken.
// m_axis stalls back up through a two-entry queue and the two front stages.
module symmetric_four_index_packed_store_core
  import sfips_pkg::*;
#(
  parameter int unsigned MaxBasis = MAX_BASIS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [BASIS_W-1:0] cfg_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // index_a[5:0], index_b[11:6], index_c[17:12], index_d[23:18], write_value[87:24]
  input  logic [87:0]        s_axis_tdata,
  // func
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // read_value[63:0]
  output logic [63:0]        m_axis_tdata,
  // range_error
  output logic               m_axis_tuser
);

  localparam int unsigned PairCount  = MaxBasis * (MaxBasis + 1) / 2;
  localparam int unsigned EntryCount = PairCount * (PairCount + 1) / 2;
  localparam int unsigned AddrW      = $clog2(EntryCount);
  localparam int unsigned QW         = OP_W + AddrW + VALUE_W;

  logic               clearing;
  logic               fq_valid, fq_ready, bq_valid, bq_ready;
  op_t                f_op, b_op;
  logic [AddrW-1:0]   f_addr, b_addr;
  logic [VALUE_W-1:0] f_wdata, b_wdata;
  logic [QW-1:0]      bq_data;

  assign cfg_ready_o = 1'b1;

  sfips_front #(
    .MaxBasis (MaxBasis)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .hold_i        (clearing),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .func_i        (s_axis_tuser),
    .index_a_i     (s_axis_tdata[5:0]),
    .index_b_i     (s_axis_tdata[11:6]),
    .index_c_i     (s_axis_tdata[17:12]),
    .index_d_i     (s_axis_tdata[23:18]),
    .write_value_i (s_axis_tdata[87:24]),
    .q_valid_o     (fq_valid),
    .q_ready_i     (fq_ready),
    .q_op_o        (f_op),
    .q_addr_o      (f_addr),
    .q_wdata_o     (f_wdata)
  );

  sfips_fifo #(
    .Width (QW),
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  ({f_op, f_addr, f_wdata}),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_data_o   (bq_data)
  );

  assign b_op    = bq_data[QW-1 -: OP_W];
  assign b_addr  = bq_data[VALUE_W +: AddrW];
  assign b_wdata = bq_data[VALUE_W-1:0];

  sfips_back #(
    .MaxBasis (MaxBasis)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clearing_o    (clearing),
    .q_valid_i     (bq_valid),
    .q_ready_o     (bq_ready),
    .q_op_i        (b_op),
    .q_addr_i      (b_addr),
    .q_wdata_i     (b_wdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .read_value_o  (m_axis_tdata),
    .range_error_o (m_axis_tuser)
  );

endmodule

// ===== src/sfips_ram.sv =====
module sfips_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sfips_fifo.sv =====
module sfips_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/sfips_front.sv =====
module sfips_front
  import sfips_pkg::*;
#(
  parameter int unsigned MaxBasis = MAX_BASIS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               hold_i,
  input  logic               cfg_valid_i,
  input  logic [BASIS_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [IDX_W-1:0]   index_a_i,
  input  logic [IDX_W-1:0]   index_b_i,
  input  logic [IDX_W-1:0]   index_c_i,
  input  logic [IDX_W-1:0]   index_d_i,
  input  logic [VALUE_W-1:0] write_value_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output op_t                q_op_o,
  output logic [$clog2((MaxBasis*(MaxBasis+1)/2)*((MaxBasis*(MaxBasis+1)/2)+1)/2)-1:0]
                             q_addr_o,
  output logic [VALUE_W-1:0] q_wdata_o
);

  localparam int unsigned PairCount  = MaxBasis * (MaxBasis + 1) / 2;
  localparam int unsigned EntryCount = PairCount * (PairCount + 1) / 2;
  localparam int unsigned PairW      = $clog2(PairCount);
  localparam int unsigned AddrW      = $clog2(EntryCount);
  localparam int unsigned LimW       = IDX_W + 1;
  localparam int unsigned Prod1W     = 2 * IDX_W + 1;
  localparam int unsigned Prod2W     = 2 * PairW + 1;

  function automatic logic [Prod1W-2:0] fold_idx(input logic [IDX_W-1:0] x,
                                                 input logic [IDX_W-1:0] y);
    logic [IDX_W-1:0]  hi;
    logic [IDX_W-1:0]  lo;
    logic [Prod1W-1:0] prod;
    hi   = (x > y) ? x : y;
    lo   = (x > y) ? y : x;
    prod = Prod1W'(hi) * (Prod1W'(hi) + Prod1W'(1));
    return prod[Prod1W-1:1] + (Prod1W-1)'(lo);
  endfunction

  function automatic logic [Prod2W-2:0] fold_pair(input logic [PairW-1:0] x,
                                                  input logic [PairW-1:0] y);
    logic [PairW-1:0]  hi;
    logic [PairW-1:0]  lo;
    logic [Prod2W-1:0] prod;
    hi   = (x > y) ? x : y;
    lo   = (x > y) ? y : x;
    prod = Prod2W'(hi) * (Prod2W'(hi) + Prod2W'(1));
    return prod[Prod2W-1:1] + (Prod2W-1)'(lo);
  endfunction

  logic [BASIS_W-1:0] basis_q;
  logic [LimW-1:0]    limit;
  logic               in_err;
  logic               accept, s1_rdy, s2_rdy;
  logic [Prod1W-2:0]  ab_full, cd_full;
  logic [Prod2W-2:0]  addr_full;

  logic               s1_v_q, s1_v_d;
  op_t                s1_op_q;
  logic [PairW-1:0]   s1_ab_q, s1_cd_q;
  logic [VALUE_W-1:0] s1_wdata_q;

  logic               s2_v_q, s2_v_d;
  op_t                s2_op_q;
  logic [AddrW-1:0]   s2_addr_q;
  logic [VALUE_W-1:0] s2_wdata_q;

  // basis_count above MaxBasis acts as MaxBasis
  assign limit = (LimW'(basis_q) > LimW'(MaxBasis)) ? LimW'(MaxBasis) : LimW'(basis_q);
  assign in_err = (LimW'(index_a_i) >= limit) || (LimW'(index_b_i) >= limit) ||
                  (LimW'(index_c_i) >= limit) || (LimW'(index_d_i) >= limit);

  assign ab_full   = fold_idx(index_a_i, index_b_i);
  assign cd_full   = fold_idx(index_c_i, index_d_i);
  assign addr_full = fold_pair(s1_ab_q, s1_cd_q);

  assign s2_rdy     = !s2_v_q || q_ready_i;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy && !hold_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    s1_v_d = s1_v_q;
    s2_v_d = s2_v_q;
    if (s1_rdy) begin
      s1_v_d = accept;
    end
    if (s2_rdy) begin
      s2_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      basis_q <= BASIS_RESET;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        basis_q <= cfg_data_i;
      end
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q.wr  <= (func_i == FUNC_WRITE);
      s1_op_q.err <= in_err;
      s1_ab_q     <= ab_full[PairW-1:0];
      s1_cd_q     <= cd_full[PairW-1:0];
      s1_wdata_q  <= write_value_i;
    end
    if (s1_v_q && s2_rdy) begin
      s2_op_q    <= s1_op_q;
      s2_addr_q  <= addr_full[AddrW-1:0];
      s2_wdata_q <= s1_wdata_q;
    end
  end

  assign q_valid_o = s2_v_q;
  assign q_op_o    = s2_op_q;
  assign q_addr_o  = s2_addr_q;
  assign q_wdata_o = s2_wdata_q;

endmodule

// ===== src/sfips_back.sv =====
module sfips_back
  import sfips_pkg::*;
#(
  parameter int unsigned MaxBasis = MAX_BASIS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  output logic               clearing_o,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  op_t                q_op_i,
  input  logic [$clog2((MaxBasis*(MaxBasis+1)/2)*((MaxBasis*(MaxBasis+1)/2)+1)/2)-1:0]
                             q_addr_i,
  input  logic [VALUE_W-1:0] q_wdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [VALUE_W-1:0] read_value_o,
  output logic               range_error_o
);

  localparam int unsigned PairCount  = MaxBasis * (MaxBasis + 1) / 2;
  localparam int unsigned EntryCount = PairCount * (PairCount + 1) / 2;
  localparam int unsigned AddrW      = $clog2(EntryCount);

  logic               clr_q, clr_d;
  logic [AddrW-1:0]   clr_addr_q, clr_addr_d;
  logic               pop;
  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [VALUE_W-1:0] ram_wdata, ram_rdata;

  logic               p_v_q, p_rd_q, p_err_q;
  logic               o_v_q, o_v_d;
  logic [VALUE_W-1:0] o_data_q;
  logic               o_err_q;

  // one beat in flight between RAM read and output register
  assign pop       = q_valid_i && !clr_q && !p_v_q && (!o_v_q || out_ready_i);
  assign q_ready_o = pop;

  assign ram_we    = clr_q || (pop && q_op_i.wr && !q_op_i.err);
  assign ram_waddr = clr_q ? clr_addr_q : q_addr_i;
  assign ram_wdata = clr_q ? '0 : q_wdata_i;

  sfips_ram #(
    .Width (VALUE_W),
    .Depth (EntryCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (pop),
    .raddr_i (q_addr_i),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      if (clr_addr_q == AddrW'(EntryCount - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AddrW'(1);
      end
    end
    o_v_d = o_v_q;
    if (p_v_q) begin
      o_v_d = 1'b1;
    end else if (out_ready_i) begin
      o_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      p_v_q      <= 1'b0;
      o_v_q      <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      p_v_q      <= pop;
      o_v_q      <= o_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      p_rd_q  <= !q_op_i.wr && !q_op_i.err;
      p_err_q <= q_op_i.err;
    end
    if (p_v_q) begin
      o_data_q <= p_rd_q ? ram_rdata : '0;
      o_err_q  <= p_err_q;
    end
  end

  assign clearing_o    = clr_q;
  assign out_valid_o   = o_v_q;
  assign read_value_o  = o_data_q;
  assign range_error_o = o_err_q;

endmodule

// ===== src/sfips_checker.sv =====
module sfips_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic [3:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 4'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 4'd1;
    end
  end

  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input taken during clearing pass");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 64'd0))
    else $error("range error beat with nonzero data");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pend_q != 4'd0))
    else $error("result beat without pending input");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output beat changed");

endmodule

bind symmetric_four_index_packed_store_core sfips_checker u_chk (.*);

// ===== test/tb_symmetric_four_index_packed_store_core.sv =====
import sfips_pkg::*;

class packed_store_model;
  localparam int unsigned PAIRS = MAX_BASIS_DEF * (MAX_BASIS_DEF + 1) / 2;
  localparam int unsigned WORDS = PAIRS * (PAIRS + 1) / 2;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               range_err;
  } reply_t;

  logic [VALUE_W-1:0] words [WORDS];
  logic [BASIS_W-1:0] basis;
  reply_t             due_replies[$];
  int unsigned        mismatches;

  function new();
    foreach (words[i]) words[i] = '0;
    basis = BASIS_RESET;
    mismatches = 0;
  endfunction

  function int unsigned fold(int unsigned x, int unsigned y);
    int unsigned hi;
    int unsigned lo;
    hi = (x > y) ? x : y;
    lo = (x > y) ? y : x;
    return hi * (hi + 1) / 2 + lo;
  endfunction

  function void note_access(logic fn, logic [IDX_W-1:0] a, logic [IDX_W-1:0] b,
                            logic [IDX_W-1:0] c, logic [IDX_W-1:0] d,
                            logic [VALUE_W-1:0] wv);
    int unsigned lim;
    int unsigned addr;
    reply_t      r;
    lim = (basis > MAX_BASIS_DEF) ? MAX_BASIS_DEF : basis;
    r.value = '0;
    r.range_err = (a >= lim) || (b >= lim) || (c >= lim) || (d >= lim);
    if (!r.range_err) begin
      addr = fold(fold(a, b), fold(c, d));
      if (fn == FUNC_WRITE) begin
        words[addr] = wv;
      end else begin
        r.value = words[addr];
      end
    end
    due_replies.push_back(r);
  endfunction

  function void check_reply(logic [VALUE_W-1:0] value, logic range_err);
    reply_t r;
    if (due_replies.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected beat value=%h range_error=%b", $time, value, range_err);
      return;
    end
    r = due_replies.pop_front();
    if (value !== r.value) begin
      mismatches++;
      $display("%0t: read_value expected %h actual %h", $time, r.value, value);
    end
    if (range_err !== r.range_err) begin
      mismatches++;
      $display("%0t: range_error expected %b actual %b", $time, r.range_err, range_err);
    end
  endfunction
endclass

module tb_symmetric_four_index_packed_store_core;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] d;
  } quad_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [BASIS_W-1:0] cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [87:0]        s_axis_tdata = '0;
  logic               s_axis_tuser = FUNC_READ;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [63:0]        m_axis_tdata;
  logic               m_axis_tuser;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  packed_store_model store = new();
  quad_t             written[$];

  symmetric_four_index_packed_store_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      store.check_reply(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    #(400_000 * 12);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic quad_t permute(quad_t q, int unsigned k);
    quad_t p;
    p = q;
    if (k[0]) {p.a, p.b} = {q.b, q.a};
    if (k[1]) {p.c, p.d} = {q.d, q.c};
    if (k[2]) {p.a, p.b, p.c, p.d} = {p.c, p.d, p.a, p.b};
    return p;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_access(logic fn, quad_t q, logic [63:0] wv);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= fn;
    s_axis_tdata  <= {wv, q.d, q.c, q.b, q.a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    store.note_access(fn, q.a, q.b, q.c, q.d, wv);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (store.due_replies.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_basis(logic [BASIS_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    store.basis = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_access();
    int unsigned lim;
    int unsigned r;
    quad_t       q;
    lim = (store.basis > MAX_BASIS_DEF) ? MAX_BASIS_DEF : store.basis;
    r = $urandom_range(99);
    if (lim == 0 || r < 10) begin
      q = '{IDX_W'($urandom_range(63)), IDX_W'($urandom_range(63)),
            IDX_W'($urandom_range(63)), IDX_W'($urandom_range(63))};
      send_access(1'($urandom_range(1)), q, rand64());
    end else if (r < 45) begin
      q = '{IDX_W'($urandom_range(lim - 1)), IDX_W'($urandom_range(lim - 1)),
            IDX_W'($urandom_range(lim - 1)), IDX_W'($urandom_range(lim - 1))};
      written.push_back(q);
      if (written.size() > 32) void'(written.pop_front());
      send_access(FUNC_WRITE, q, rand64());
    end else if (r < 85 && written.size() != 0) begin
      q = permute(written[$urandom_range(written.size() - 1)], $urandom_range(7));
      send_access(FUNC_READ, q, rand64());
    end else begin
      q = '{IDX_W'($urandom_range(lim - 1)), IDX_W'($urandom_range(lim - 1)),
            IDX_W'($urandom_range(lim - 1)), IDX_W'($urandom_range(lim - 1))};
      send_access(FUNC_READ, q, rand64());
    end
  endtask

  initial begin
    quad_t       t;
    int unsigned idle_plan [4][2];
    logic [BASIS_W-1:0] basis_plan [4];
    idle_plan = '{'{0, 0}, '{60, 0}, '{0, 60}, '{19, 19}};
    basis_plan = '{5'd16, 5'($urandom_range(2, 15)), 5'd31, 5'($urandom_range(31))};
    t = '{6'd3, 6'd7, 6'd11, 6'd2};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // taken during the clearing pass
    write_basis(5'd16);
    send_access(FUNC_READ, '{6'd0, 6'd0, 6'd0, 6'd0}, '0);
    send_access(FUNC_WRITE, '{6'd0, 6'd0, 6'd0, 6'd0}, '1);
    send_access(FUNC_READ, '{6'd0, 6'd0, 6'd0, 6'd0}, '0);
    send_access(FUNC_WRITE, '{6'd15, 6'd15, 6'd15, 6'd15}, 64'h5555_5555_5555_5555);
    send_access(FUNC_WRITE, t, 64'hA5A5_0F0F_C3C3_F00F);
    for (int k = 0; k < 8; k++) send_access(FUNC_READ, permute(t, k), '1);
    send_access(FUNC_READ, '{6'd15, 6'd15, 6'd15, 6'd15}, '0);
    // out-of-range accesses report range_error and their writes are dropped
    send_access(FUNC_WRITE, '{6'd16, 6'd0, 6'd0, 6'd0}, 64'h1234);
    send_access(FUNC_WRITE, '{6'd0, 6'd63, 6'd0, 6'd0}, 64'h5678);
    send_access(FUNC_READ, '{6'd0, 6'd0, 6'd63, 6'd63}, '0);
    send_access(FUNC_WRITE, '{6'd63, 6'd63, 6'd63, 6'd63}, '0);
    send_access(FUNC_READ, '{6'd0, 6'd0, 6'd0, 6'd0}, '0);
    drain();

    // zero basis: everything errors
    write_basis(5'd0);
    send_access(FUNC_WRITE, '{6'd0, 6'd0, 6'd0, 6'd0}, '0);
    send_access(FUNC_READ, '{6'd0, 6'd0, 6'd0, 6'd0}, '0);
    drain();

    // above MAX_BASIS clamps
    write_basis(5'd31);
    send_access(FUNC_READ, '{6'd15, 6'd15, 6'd15, 6'd15}, '0);
    send_access(FUNC_READ, '{6'd0, 6'd0, 6'd0, 6'd16}, '0);
    drain();

    write_basis(5'd1);
    send_access(FUNC_WRITE, '{6'd0, 6'd0, 6'd0, 6'd0}, 64'hDEAD_BEEF_0000_0001);
    send_access(FUNC_READ, '{6'd0, 6'd0, 6'd0, 6'd0}, '0);
    send_access(FUNC_READ, '{6'd1, 6'd0, 6'd0, 6'd0}, '0);
    drain();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p][0];
      recv_stall_pct = idle_plan[p][1];
      write_basis(basis_plan[p]);
      for (int i = 0; i < 500; i++) random_access();
      drain();
    end

    recv_stall_pct = 0;
    drain();
    if (store.mismatches == 0 && store.due_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
